// ===== src/pwn_pkg.sv =====
package pwn_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int WINDING_WIDTH  = 16;
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH    = PROD_WIDTH + 1;
  localparam int CFG_DATA_WIDTH = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int CFG_ADDR_WIDTH = (COORD_WIDTH > 32) ? 4 : 3;

  // register index, taken from the top address bit
  localparam logic REG_QUERY_X = 1'b0;
  localparam logic REG_QUERY_Y = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          is_last;
  } vertex_t;

  typedef struct packed {
    logic signed [WINDING_WIDTH-1:0] winding;
    logic                            on_boundary;
  } result_t;

  // per-edge facts that ride along with the products
  typedef struct packed {
    logic last;
    logic has_edge;
    logic in_box;
    logic up;
    logic down;
  } edge_flags_t;

endpackage

// ===== src/polygon_winding_number.sv =====
// Winding number of a configured query point against a streamed polygon.
//
// Input channel (in_*): one vertex per beat; is_last closes the polygon.
// Each beat forms the edge from the previous vertex to this one.
// Result channel (out_*): one beat per polygon, issued for the is_last vertex:
// winding = 0 and on_boundary = 1 if the point lies on an edge, winding = 1
// if fewer than two vertices came, else the saturated winding count.
// Config port (cfg_*): query_x at byte address 0, query_y at 4. Write only
// while no polygon is in flight.
//
// Throughput: one vertex per cycle while in_stall is low. The last vertex passes
// the difference, multiply and cross-sign registers in turn, then the accumulate
// loads the result into the output register.
// Receiver stall: vertices keep flowing while a result waits; the pipeline
// freezes (in_stall high) only when a second result reaches the end before
// the first is taken.
// Reset: query point zero, polygon state cleared, pipeline empty.
module polygon_winding_number (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pwn_pkg::vertex_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pwn_pkg::result_t                    out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pwn_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [pwn_pkg::CFG_DATA_WIDTH-1:0]  cfg_pwdata,
  output logic [pwn_pkg::CFG_DATA_WIDTH-1:0]  cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CW = pwn_pkg::COORD_WIDTH;
  localparam int WW = pwn_pkg::WINDING_WIDTH;
  localparam int DW = pwn_pkg::DIFF_WIDTH;
  localparam int PW = pwn_pkg::PROD_WIDTH;
  localparam int XW = pwn_pkg::CROSS_WIDTH;
  localparam logic signed [WW-1:0] WINDING_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] WINDING_MIN = {1'b1, {(WW-1){1'b0}}};
  localparam logic signed [WW-1:0] WINDING_ONE = WW'(1);

  // configuration
  logic signed [CW-1:0] query_x_r;
  logic signed [CW-1:0] query_y_r;
  logic                 cfg_write;
  logic                 cfg_index;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[pwn_pkg::CFG_ADDR_WIDTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= '0;
      query_y_r <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pwn_pkg::REG_QUERY_X: query_x_r <= cfg_pwdata[CW-1:0];
        pwn_pkg::REG_QUERY_Y: query_y_r <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      pwn_pkg::REG_QUERY_X: cfg_prdata = pwn_pkg::CFG_DATA_WIDTH'(query_x_r);
      pwn_pkg::REG_QUERY_Y: cfg_prdata = pwn_pkg::CFG_DATA_WIDTH'(query_y_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic advance;
  logic in_accept;
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  pwn_pkg::edge_flags_t s1_flags_r, s2_flags_r, s3_flags_r;
  logic out_valid_r;

  // freeze only when a result is ready to leave and the slot is still held
  assign advance   = !(s3_valid_r && s3_flags_r.last && out_valid_r && out_stall);
  assign in_stall  = !advance;
  assign in_accept = in_valid && advance;

  // stage 0: edge differences and comparisons against the previous vertex
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic                 have_prev_r;
  logic signed [DW-1:0] dx, dy, qdx, qdy;
  pwn_pkg::edge_flags_t s0_flags;
  logic signed [CW-1:0] vx, vy;

  assign vx  = in_data.vertex_x;
  assign vy  = in_data.vertex_y;
  assign dx  = DW'(vx) - DW'(prev_x_r);
  assign dy  = DW'(vy) - DW'(prev_y_r);
  assign qdx = DW'(query_x_r) - DW'(prev_x_r);
  assign qdy = DW'(query_y_r) - DW'(prev_y_r);

  always_comb begin
    s0_flags.last     = in_data.is_last;
    s0_flags.has_edge = have_prev_r;
    s0_flags.in_box   = ((prev_x_r <= query_x_r && query_x_r <= vx) ||
                         (vx <= query_x_r && query_x_r <= prev_x_r)) &&
                        ((prev_y_r <= query_y_r && query_y_r <= vy) ||
                         (vy <= query_y_r && query_y_r <= prev_y_r));
    s0_flags.up       = (prev_y_r <= query_y_r) && (vy > query_y_r);
    s0_flags.down     = (prev_y_r > query_y_r) && (vy <= query_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else if (in_accept) begin
      have_prev_r <= !in_data.is_last;
      prev_x_r    <= in_data.is_last ? '0 : vx;
      prev_y_r    <= in_data.is_last ? '0 : vy;
    end
  end

  // stage 1 -> 2: the two cross-product terms
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_qdx_r, s1_qdy_r;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [PW-1:0] s2_prod_a_r, s2_prod_b_r;

  assign prod_a = s1_dx_r * s1_qdy_r;
  assign prod_b = s1_dy_r * s1_qdx_r;

  // stage 2 -> 3: exact sign of the cross product
  logic signed [XW-1:0] cross_val;
  logic s3_pos_r, s3_neg_r, s3_zero_r;

  assign cross_val = XW'(s2_prod_a_r) - XW'(s2_prod_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_flags_r  <= s0_flags;
      s1_dx_r     <= dx;
      s1_dy_r     <= dy;
      s1_qdx_r    <= qdx;
      s1_qdy_r    <= qdy;
      s2_flags_r  <= s1_flags_r;
      s2_prod_a_r <= prod_a;
      s2_prod_b_r <= prod_b;
      s3_flags_r  <= s2_flags_r;
      s3_pos_r    <= !cross_val[XW-1] && (cross_val != '0);
      s3_neg_r    <= cross_val[XW-1];
      s3_zero_r   <= (cross_val == '0);
    end
  end

  // stage 3: winding accumulate and result
  logic signed [WW-1:0] winding_acc_r, winding_step;
  logic                 edge_hit_r, hit_now, hit_step, live, inc, dec;
  logic                 out_load;
  pwn_pkg::result_t     result, out_data_r;

  assign live     = s3_valid_r && s3_flags_r.has_edge && !edge_hit_r;
  assign hit_now  = live && s3_zero_r && s3_flags_r.in_box;
  assign inc      = live && !hit_now && s3_flags_r.up && s3_pos_r &&
                    (winding_acc_r != WINDING_MAX);
  assign dec      = live && !hit_now && s3_flags_r.down && s3_neg_r &&
                    (winding_acc_r != WINDING_MIN);
  assign hit_step = edge_hit_r || hit_now;

  always_comb begin
    if (inc) begin
      winding_step = winding_acc_r + WINDING_ONE;
    end else if (dec) begin
      winding_step = winding_acc_r - WINDING_ONE;
    end else begin
      winding_step = winding_acc_r;
    end
  end

  always_comb begin
    result.on_boundary = hit_step;
    if (hit_step) begin
      result.winding = '0;
    end else if (!s3_flags_r.has_edge) begin
      result.winding = WINDING_ONE;
    end else begin
      result.winding = winding_step;
    end
  end

  assign out_load = advance && s3_valid_r && s3_flags_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      winding_acc_r <= '0;
      edge_hit_r    <= 1'b0;
    end else if (advance && s3_valid_r) begin
      winding_acc_r <= s3_flags_r.last ? '0 : winding_step;
      edge_hit_r    <= s3_flags_r.last ? 1'b0 : hit_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s3_valid_r && s3_flags_r.last))
    else $error("input stalled without a blocked result");

  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("closing vertex did not produce a result");

  a_boundary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.on_boundary) |-> (out_data_r.winding == '0))
    else $error("boundary result with nonzero winding");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (winding_acc_r == '0 && !edge_hit_r))
    else $error("polygon state not cleared after result");

  a_hit_freezes_count: assert property (@(posedge clk) disable iff (!rst_n)
    edge_hit_r |-> (!inc && !dec))
    else $error("winding count moved after a boundary hit");

endmodule
